>>> sv/johnson_all_pairs_shortest_path_assert.svh
// Assertion macros for the all-pairs shortest path block.
// Used by the top level; no other dependencies.
`ifndef JOHNSON_ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define JOHNSON_ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define APSP_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define APSP_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define APSP_ASSERT_IMPL(lbl, a, c)
`define APSP_ASSERT_NEXT(lbl, a, c)
`endif
`endif

>>> sv/apsp_pkg.sv
// Shared types and constants for the all-pairs shortest path block.
// No dependencies.
`timescale 1ns / 1ps
package apsp_pkg;
  localparam int DistW = 24;
  localparam int WeightW = 16;

  typedef struct packed {
    logic [2:0]         from_vertex;
    logic [2:0]         to_vertex;
    logic signed [15:0] edge_weight;
    logic               last_edge;
  } edge_req_t;

  typedef struct packed {
    logic [2:0]         source_vertex;
    logic [2:0]         dest_vertex;
    logic signed [23:0] path_distance;
    logic               reachable;
    logic               last_result;
  } dist_res_t;

  // Controller commands to the datapath
  typedef enum logic [2:0] {
    CMD_NONE, CMD_BF_INIT, CMD_BF_RELAX, CMD_DJ_INIT, CMD_DJ_SELECT,
    CMD_DJ_RELAX, CMD_EMIT, CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [2:0] u;
    logic [2:0] v;
    logic [2:0] src;
  } dp_cmd_t;

  typedef struct packed {
    logic       sel_found;
    logic [2:0] sel_vertex;
  } dp_status_t;

  // Saturate a wide signed value to the distance range
  function automatic logic signed [23:0] sat24(input logic signed [27:0] x);
    logic signed [27:0] hi;
    logic signed [27:0] lo;
    begin
      hi = 28'sd8388607;
      lo = -28'sd8388608;
      if (x > hi) sat24 = 24'sh7FFFFF;
      else if (x < lo) sat24 = 24'sh800000;
      else sat24 = x[23:0];
    end
  endfunction
endpackage

>>> sv/apsp_datapath.sv
// Datapath: edge store, potentials, tentative distances, result register.
// Depends on apsp_pkg.
`timescale 1ns / 1ps
module apsp_datapath #(
  parameter int VERTICES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load_en,
  input  apsp_pkg::edge_req_t   load_req,
  input  apsp_pkg::dp_cmd_t     cmd,
  input  logic                  emit_last,
  output apsp_pkg::dp_status_t  status,
  output apsp_pkg::dist_res_t   res
);
  import apsp_pkg::*;
  localparam int NE = VERTICES * VERTICES;
  localparam int VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int EW = $clog2(NE);

  logic signed [15:0] weight_store [NE];
  logic [NE-1:0]      edge_present;
  logic signed [23:0] potential [VERTICES];
  logic signed [23:0] tentative_dist [VERTICES];
  logic [VERTICES-1:0] settled;
  logic [VERTICES-1:0] reached;

  logic [EW-1:0] load_idx;
  logic [EW-1:0] uv_idx;
  logic          load_ok;
  assign load_ok  = ({1'b0, load_req.from_vertex} < 4'(VERTICES)) &&
                    ({1'b0, load_req.to_vertex} < 4'(VERTICES));
  assign load_idx = EW'(load_req.from_vertex * VERTICES + load_req.to_vertex);
  assign uv_idx   = EW'(cmd.u * VERTICES + cmd.v);

  // Edge store write
  always_ff @(posedge clk) begin
    if (load_en && load_ok && load_req.edge_weight != 0) begin
      weight_store[load_idx] <= load_req.edge_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_present <= '0;
    end else if (cmd.op == CMD_CLEAR) begin
      edge_present <= '0;
    end else if (load_en && load_ok) begin
      edge_present[load_idx] <= (load_req.edge_weight != 0);
    end
  end

  // Lowest-index unsettled reached vertex of least distance
  always_comb begin
    status.sel_found  = 1'b0;
    status.sel_vertex = '0;
    for (int i = 0; i < VERTICES; i++) begin
      if (!settled[i] && reached[i]) begin
        if (!status.sel_found ||
            tentative_dist[i] < tentative_dist[status.sel_vertex[VW-1:0]]) begin
          status.sel_vertex = 3'(i);
        end
        status.sel_found = 1'b1;
      end
    end
  end

  // Relax terms
  logic signed [23:0] hu;
  logic signed [23:0] hv;
  logic signed [27:0] bf_cand;
  logic signed [27:0] dj_cand;
  logic signed [27:0] out_dist;
  logic signed [23:0] hsrc;
  assign hu      = potential[cmd.u[VW-1:0]];
  assign hv      = potential[cmd.v[VW-1:0]];
  assign hsrc    = potential[cmd.src[VW-1:0]];
  assign bf_cand = 28'(hu) + 28'(weight_store[uv_idx]);
  assign dj_cand = 28'(tentative_dist[cmd.u[VW-1:0]]) + 28'(weight_store[uv_idx])
                 + 28'(hu) - 28'(hv);
  assign out_dist = 28'(tentative_dist[cmd.v[VW-1:0]]) + 28'(hv) - 28'(hsrc);

  always_ff @(posedge clk) begin
    if (rst) begin
      settled <= '0;
      reached <= '0;
    end else begin
      case (cmd.op)
        CMD_DJ_INIT: begin
          settled <= '0;
          // only the source starts out reached
          reached <= VERTICES'(1) << cmd.src[VW-1:0];
        end
        CMD_DJ_SELECT: begin
          if (status.sel_found) settled[status.sel_vertex[VW-1:0]] <= 1'b1;
        end
        CMD_DJ_RELAX: begin
          if (!settled[cmd.v[VW-1:0]] && edge_present[uv_idx] &&
              (!reached[cmd.v[VW-1:0]] ||
               dj_cand < 28'(tentative_dist[cmd.v[VW-1:0]]))) begin
            reached[cmd.v[VW-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_BF_INIT: begin
        for (int i = 0; i < VERTICES; i++) potential[i] <= '0;
      end
      CMD_BF_RELAX: begin
        if (edge_present[uv_idx] && bf_cand < 28'(hv)) potential[cmd.v[VW-1:0]] <= sat24(bf_cand);
      end
      CMD_DJ_INIT: begin
        tentative_dist[cmd.src[VW-1:0]] <= '0;
      end
      CMD_DJ_RELAX: begin
        if (!settled[cmd.v[VW-1:0]] && edge_present[uv_idx] &&
            (!reached[cmd.v[VW-1:0]] ||
             dj_cand < 28'(tentative_dist[cmd.v[VW-1:0]]))) begin
          tentative_dist[cmd.v[VW-1:0]] <= sat24(dj_cand);
        end
      end
      CMD_EMIT: begin
        res.source_vertex <= cmd.src;
        res.dest_vertex   <= cmd.v;
        res.reachable     <= reached[cmd.v[VW-1:0]];
        res.path_distance <= reached[cmd.v[VW-1:0]] ? sat24(out_dist) : '0;
        res.last_result   <= emit_last;
      end
      default: ;
    endcase
  end
endmodule

>>> sv/apsp_ctrl.sv
// Controller: sequences loading, Bellman-Ford, Dijkstra and result output.
// Depends on apsp_pkg.
`timescale 1ns / 1ps
module apsp_ctrl #(
  parameter int VERTICES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 load_en,
  output apsp_pkg::dp_cmd_t    cmd,
  output logic                 emit_last,
  input  apsp_pkg::dp_status_t status
);
  import apsp_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_BF, S_DJ_INIT, S_DJ_SEL, S_DJ_RELAX, S_EMIT, S_WAIT
  } state_t;

  state_t     state;
  logic [3:0] pass;
  logic [2:0] u;
  logic [2:0] v;
  logic [2:0] src;

  localparam logic [2:0] VLast = 3'(VERTICES - 1);

  assign in_ready = (state == S_LOAD);
  assign load_en  = in_valid && in_ready;

  // Command decode
  always_comb begin
    cmd.op  = CMD_NONE;
    cmd.u   = u;
    cmd.v   = v;
    cmd.src = src;
    emit_last = (src == VLast) && (v == VLast);
    unique case (state)
      S_LOAD:     if (load_en && in_last) cmd.op = CMD_BF_INIT;
      S_BF:       cmd.op = CMD_BF_RELAX;
      S_DJ_INIT:  cmd.op = CMD_DJ_INIT;
      S_DJ_SEL:   cmd.op = CMD_DJ_SELECT;
      S_DJ_RELAX: cmd.op = CMD_DJ_RELAX;
      S_EMIT:     if (!out_valid || out_ready) cmd.op = CMD_EMIT;
      S_WAIT:     if (out_ready) cmd.op = CMD_CLEAR;
      default:    cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      out_valid <= 1'b0;
      pass <= '0;
      u <= '0;
      v <= '0;
      src <= '0;
    end else begin
      // a result taken in S_EMIT is replaced by the next one below
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (load_en && in_last) begin
            state <= S_BF;
            pass <= '0;
            u <= '0;
            v <= '0;
          end
        end
        S_BF: begin
          if (v != VLast) v <= v + 3'd1;
          else begin
            v <= '0;
            if (u != VLast) u <= u + 3'd1;
            else begin
              u <= '0;
              if (pass != 4'(VERTICES - 1)) pass <= pass + 4'd1;
              else begin
                state <= S_DJ_INIT;
                src <= '0;
              end
            end
          end
        end
        S_DJ_INIT: state <= S_DJ_SEL;
        S_DJ_SEL: begin
          if (status.sel_found) begin
            u <= status.sel_vertex;
            v <= '0;
            state <= S_DJ_RELAX;
          end else begin
            v <= '0;
            state <= S_EMIT;
          end
        end
        S_DJ_RELAX: begin
          if (v != VLast) v <= v + 3'd1;
          else state <= S_DJ_SEL;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (v != VLast) v <= v + 3'd1;
            else if (src != VLast) begin
              src <= src + 3'd1;
              state <= S_DJ_INIT;
            end else state <= S_WAIT;
          end
        end
        S_WAIT: if (out_ready) state <= S_LOAD;
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

>>> sv/johnson_all_pairs_shortest_path.sv
// All-pairs shortest paths (Johnson). Edges load one per cycle; after the edge
// marked last, Bellman-Ford makes VERTICES passes over all vertex pairs, then
// each source runs Dijkstra and emits VERTICES results, one per cycle while
// out_ready stays high; every relaxation goes through the single shared relax
// unit. Input stalls during the run; the edge store clears after the last
// result is taken. Depends on apsp_pkg and the assertion header.
`timescale 1ns / 1ps
`include "johnson_all_pairs_shortest_path_assert.svh"
module johnson_all_pairs_shortest_path #(
  parameter int VERTICES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  apsp_pkg::edge_req_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apsp_pkg::dist_res_t  out_data
);
  import apsp_pkg::*;

  logic       load_en;
  logic       emit_last;
  dp_cmd_t    cmd;
  dp_status_t status;

  apsp_ctrl #(.VERTICES(VERTICES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_data.last_edge),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .load_en(load_en), .cmd(cmd), .emit_last(emit_last), .status(status)
  );

  apsp_datapath #(.VERTICES(VERTICES)) u_dp (
    .clk(clk), .rst(rst), .load_en(load_en), .load_req(in_data), .cmd(cmd),
    .emit_last(emit_last), .status(status), .res(out_data)
  );

  `APSP_ASSERT_IMPL(a_no_load_while_out, out_valid, !in_ready)
  `APSP_ASSERT_NEXT(a_last_ends_run, out_valid && out_ready && out_data.last_result, in_ready)
endmodule

>>> tb/sv/johnson_all_pairs_shortest_path_tb.sv
// Testbench for the Johnson all-pairs shortest path block: loads random and
// directed edge graphs, predicts every distance result, and checks them in order.
// Depends on apsp_pkg and the block's RTL.
`timescale 1ns / 1ps
module johnson_all_pairs_shortest_path_tb;
  import apsp_pkg::*;

  localparam int NV = 4;
  localparam int WATCHDOG_LIMIT = 20000;

  // Distance scoreboard: owns a copy of the edge store and predicts results
  class apsp_scoreboard;
    logic signed [15:0] weights[NV*NV];
    bit                 present[NV*NV];
    dist_res_t          pending[$];
    int                 errors;

    function new();
      errors = 0;
      foreach (present[i]) begin
        present[i] = 0;
        weights[i] = '0;
      end
    endfunction

    static function longint clip24(longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
    endfunction

    // Johnson: potentials, then reweighted Dijkstra per source
    function void solve_all_pairs();
      longint    pot[NV];
      longint    tdist[NV];
      bit        done[NV];
      bit        seen[NV];
      longint    cand;
      int        u;
      dist_res_t r;
      foreach (pot[i]) pot[i] = 0;
      for (int p = 0; p < NV; p++)
        for (int a = 0; a < NV; a++)
          for (int b = 0; b < NV; b++)
            if (present[a*NV+b]) begin
              cand = pot[a] + longint'(weights[a*NV+b]);
              if (cand < pot[b]) pot[b] = clip24(cand);
            end
      for (int s = 0; s < NV; s++) begin
        foreach (tdist[i]) begin
          tdist[i] = 0;
          done[i] = 0;
          seen[i] = 0;
        end
        seen[s] = 1;
        forever begin
          u = -1;
          for (int v = 0; v < NV; v++)
            if (!done[v] && seen[v] && (u < 0 || tdist[v] < tdist[u])) u = v;
          if (u < 0) break;
          done[u] = 1;
          for (int v = 0; v < NV; v++) begin
            if (done[v] || !present[u*NV+v]) continue;
            cand = tdist[u] + longint'(weights[u*NV+v]) + pot[u] - pot[v];
            if (!seen[v] || cand < tdist[v]) begin
              tdist[v] = clip24(cand);
              seen[v] = 1;
            end
          end
        end
        for (int d = 0; d < NV; d++) begin
          r.source_vertex = s[2:0];
          r.dest_vertex   = d[2:0];
          r.path_distance = seen[d] ? 24'(clip24(tdist[d] + pot[d] - pot[s])) : '0;
          r.reachable     = seen[d];
          r.last_result   = (s == NV-1) && (d == NV-1);
          pending.push_back(r);
        end
      end
      foreach (present[i]) present[i] = 0;
    endfunction

    function void note_request(edge_req_t q);
      int idx;
      if (q.from_vertex < NV && q.to_vertex < NV) begin
        idx = q.from_vertex * NV + q.to_vertex;
        if (q.edge_weight == 0) present[idx] = 0;
        else begin
          present[idx] = 1;
          weights[idx] = q.edge_weight;
        end
      end
      if (q.last_edge) solve_all_pairs();
    endfunction

    function void check_result(dist_res_t got);
      dist_res_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.source_vertex !== exp_r.source_vertex) begin
        $error("source_vertex exp %0d got %0d", exp_r.source_vertex, got.source_vertex);
        errors++;
      end
      if (got.dest_vertex !== exp_r.dest_vertex) begin
        $error("dest_vertex exp %0d got %0d", exp_r.dest_vertex, got.dest_vertex);
        errors++;
      end
      if (got.path_distance !== exp_r.path_distance) begin
        $error("path_distance exp %0d got %0d", exp_r.path_distance, got.path_distance);
        errors++;
      end
      if (got.reachable !== exp_r.reachable) begin
        $error("reachable exp %0d got %0d", exp_r.reachable, got.reachable);
        errors++;
      end
      if (got.last_result !== exp_r.last_result) begin
        $error("last_result exp %0d got %0d", exp_r.last_result, got.last_result);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  edge_req_t in_data;
  logic      out_valid;
  logic      out_ready;
  dist_res_t out_data;

  apsp_scoreboard sb;
  int  idle_cycles;
  int  rx_wait;
  bit  stim_done;
  bit  rx_random;

  johnson_all_pairs_shortest_path #(.VERTICES(NV)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // 4 ns clock
  initial clk = 0;
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Send one request with a random lead gap (or none); valid stays up between
  // back-to-back requests
  task automatic send_edge(input logic [2:0] fv, input logic [2:0] tv,
                           input logic signed [15:0] w, input logic last, input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{from_vertex: fv, to_vertex: tv, edge_weight: w, last_edge: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request('{from_vertex: fv, to_vertex: tv, edge_weight: w, last_edge: last});
  endtask

  // Random weight: mostly small, sometimes extreme or zero
  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 40)) - 8);
    endcase
  endfunction

  // Result side: when rx_random is set, drop ready after each result for a random wait
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_result(out_data);
      if (rx_random) begin
        rx_wait   <= $urandom_range(0, 15);
        out_ready <= 1'b0;
      end
    end else if (!out_ready) begin
      if (rx_wait <= 1) out_ready <= 1'b1;
      rx_wait <= (rx_wait > 0) ? rx_wait - 1 : 0;
    end
  end

  // Watchdog on handshake inactivity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int n;
    int cnt;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    rx_random = 1'b0;
    stim_done = 1'b0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty graph, extremes, self loop, out of range, removal, neg cycle
    send_edge(3'd0, 3'd0, 16'sd0, 1'b1, 0);
    send_edge(3'd0, 3'd1, 16'sh7FFF, 1'b0, 0);
    send_edge(3'd1, 3'd2, 16'sh7FFF, 1'b0, 0);
    send_edge(3'd2, 3'd3, 16'sh8000, 1'b0, 0);
    send_edge(3'd3, 3'd3, -16'sd5, 1'b0, 0);
    send_edge(3'd7, 3'd1, 16'sd3, 1'b0, 0);
    send_edge(3'd1, 3'd5, 16'sd3, 1'b1, 0);
    send_edge(3'd0, 3'd1, 16'sd5, 1'b0, 0);
    send_edge(3'd0, 3'd1, 16'sd2, 1'b0, 0);
    send_edge(3'd1, 3'd0, -16'sd4, 1'b0, 0);
    send_edge(3'd2, 3'd3, 16'sd9, 1'b0, 0);
    send_edge(3'd2, 3'd3, 16'sd0, 1'b0, 0);
    send_edge(3'd3, 3'd2, 16'sd1, 1'b0, 0);
    send_edge(3'd6, 3'd6, 16'sd0, 1'b1, 0);
    send_edge(3'd0, 3'd1, 16'sh8000, 1'b0, 0);
    send_edge(3'd1, 3'd2, 16'sh8000, 1'b0, 0);
    send_edge(3'd2, 3'd3, 16'sh8000, 1'b0, 0);
    send_edge(3'd3, 3'd0, 16'sh8000, 1'b1, 0);
    send_edge(3'd4, 3'd7, -16'sd1, 1'b1, 0);
    in_valid <= 1'b0;

    // Wait for every result before the random part
    rx_random = 1'b1;
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);

    // Random graphs of 1..12 edges, occasional stray vertices
    n = 0;
    while (n < 390) begin
      cnt = $urandom_range(1, 12);
      for (int k = 0; k < cnt; k++) begin
        logic [2:0] fv;
        logic [2:0] tv;
        fv = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(0, NV-1));
        tv = ($urandom_range(0, 19) == 0) ? 3'($urandom) : 3'($urandom_range(0, NV-1));
        send_edge(fv, tv, pick_weight(), k == cnt - 1, $urandom_range(0, 3) != 0);
        n++;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/apsp_pkg.sv
sv/apsp_datapath.sv
sv/apsp_ctrl.sv
sv/johnson_all_pairs_shortest_path.sv
tb/sv/johnson_all_pairs_shortest_path_tb.sv
